@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker module of the fader.
// Needs nothing but a clock, a reset and a property expression.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is checked during reset as well.
`define ASSERT_CLK_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/rlf_pkg.sv @@
// Shared constants and types of the RGB linear fader.
// Used by the fader top level, its divider and its checker; depends on nothing.
package rlf_pkg;

  localparam int NUM_LEDS_DEF = 16;

  // Field widths.
  localparam int OPCODE_W  = 2;
  localparam int SEL_W     = 5;
  localparam int COLOR_W   = 8;
  localparam int STEPS_W   = 16;
  localparam int COUNT_W   = 5;
  localparam int LED_IDX_W = 4;
  localparam int SLOPE_W   = 16;
  localparam int STL_W     = 17;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 32;

  localparam logic [COUNT_W-1:0] LED_COUNT_RST = 5'd16;

  // Command codes carried in the input tuser.
  localparam logic [OPCODE_W-1:0] OP_SET_NOW = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_FADE_TO = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_TICK    = 2'd2;

  // Fixed-point scale: slopes and positions are kept in hundredths of a level.
  localparam int SCALE     = 100;
  localparam int HALF      = 50;
  localparam int SAT_LIMIT = 25600;   // 256 levels in hundredths
  localparam int RECIP     = 5243;    // ceil(2^19 / 100)
  localparam int RECIP_SH  = 19;

  // Slope divider: |100 * diff| fits in 15 bits.
  localparam int DIV_NUM_W = 15;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  // One table entry per LED; channel 0 is red, 1 green, 2 blue.
  typedef struct packed {
    logic [STL_W-1:0]              steps_left;
    logic [2:0][SLOPE_W-1:0]       slope;
    logic [2:0][COLOR_W-1:0]       tgt;
    logic [2:0][COLOR_W-1:0]       cur;
  } led_entry_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [STEPS_W-1:0]   den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

@@ hdl/rlf_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module rlf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/rlf_div.sv @@
// Bit-serial restoring divider for the fade slope, one quotient bit per cycle.
// Depends on rlf_pkg for widths and the request and response structs.
module rlf_div (
  input  logic              clk,
  input  logic              rst,
  input  rlf_pkg::div_req_t req,
  output rlf_pkg::div_rsp_t rsp
);
  import rlf_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [STEPS_W-1:0]   rem;
  logic [STEPS_W-1:0]   den;
  logic [DIV_NUM_W-1:0] quo;

  logic [STEPS_W:0]     shifted;
  logic                 ge;
  logic [STEPS_W:0]     diff;
  logic [STEPS_W-1:0]   rem_next;

  always_comb begin
    shifted  = {rem, quo[DIV_NUM_W-1]};
    ge       = (shifted >= {1'b0, den});
    diff     = shifted - {1'b0, den};
    rem_next = ge ? diff[STEPS_W-1:0] : shifted[STEPS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem  <= '0;
        quo  <= req.num;
        den  <= req.den;
        cnt  <= DIV_CNT_W'(DIV_NUM_W);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[DIV_NUM_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

@@ hdl/rgb_linear_fader.sv @@
// RGB linear fader: per-LED color table in one RAM, walked one LED at a time.
// Each word is taken, then walked LED by LED: set_now reads, loads and writes back each LED;
// fade_to adds the bit-serial slope divider for each channel; a tick adds TA, TB and TC per
// channel for a LED mid-fade, plus any wait on the output. The next word is taken after the walk.
// Reset (synchronous, active high) empties the table at once through per-LED valid bits,
// sets led_count to 16 and drops any pending output word; no clearing pass is needed.
module rgb_linear_fader #(
  parameter int NUM_LEDS = rlf_pkg::NUM_LEDS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration: led_count
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rlf_pkg::COUNT_W-1:0]      cfg_data,
  // Command words
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // led_select[4:0], red[12:5], green[20:13], blue[28:21], steps[44:29], zero[47:45]
  input  logic [rlf_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // opcode[1:0]
  input  logic [rlf_pkg::OPCODE_W-1:0]     s_axis_tuser,
  // Color report words
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // led_index[3:0], out_red[11:4], out_green[19:12], out_blue[27:20], zero[31:28]
  output logic [rlf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic                             m_axis_tlast
);
  import rlf_pkg::*;

  localparam int IDX_W   = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int CNT_W   = $clog2(NUM_LEDS + 1);
  localparam int ENTRY_W = $bits(led_entry_t);
  localparam logic [7:0] NUM_LEDS_B = 8'(NUM_LEDS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_LOAD,
    S_FD_START,
    S_FD_WAIT,
    S_TA,
    S_TB,
    S_TC,
    S_WB
  } state_t;

  state_t state;

  // Configuration register and the number of LEDs it puts in use.
  logic [COUNT_W-1:0] led_count;
  logic [7:0]         n_b;
  logic [CNT_W-1:0]   n;

  // Fields of the incoming command word.
  logic [SEL_W-1:0]   in_sel;
  logic [2:0][COLOR_W-1:0] in_col;
  logic [STEPS_W-1:0] in_steps;
  logic [7:0]         sel_b;
  logic [CNT_W-1:0]   sel_lo;
  logic [CNT_W-1:0]   sel_hi;
  logic               sel_go;

  // Latched command.
  logic [OPCODE_W-1:0]     op;
  logic [2:0][COLOR_W-1:0] col;
  logic [STEPS_W-1:0]      steps_eff;
  logic [CNT_W-1:0]        k;
  logic [CNT_W-1:0]        hi;
  logic [CNT_W-1:0]        k_inc;
  logic [1:0]              ch;

  // Table entry being worked on and its valid bits.
  led_entry_t          work;
  led_entry_t          work_next;
  state_t              load_state;
  led_entry_t          rd_entry;
  logic [ENTRY_W-1:0]  ram_rdata;
  logic [NUM_LEDS-1:0] valid;
  logic [IDX_W-1:0]    addr;
  logic                ram_we;
  logic                ram_re;
  logic                wb_go;

  // Slope divider.
  div_req_t            div_req;
  div_rsp_t            div_rsp;
  logic                neg;
  logic [COLOR_W-1:0]  abs_diff;
  logic [SLOPE_W-1:0]  quo_ext;

  // Tick datapath.
  logic signed [SLOPE_W-1:0] m_sg;
  logic signed [STEPS_W:0]   s_sg;
  logic [14:0]               cur100;
  logic [14:0]               dest100;
  logic signed [32:0]        prod;
  logic signed [18:0]        t_a;
  logic signed [18:0]        t_b;
  logic signed [34:0]        err;
  logic                      lag;
  logic [27:0]               recip_prod;
  logic [COLOR_W-1:0]        chan_val;

  // Output register.
  logic                    out_valid;
  logic                    out_load;
  logic [LED_IDX_W-1:0]    out_idx;
  logic [2:0][COLOR_W-1:0] out_col;
  logic                    out_last;
  logic [CNT_W+LED_IDX_W-1:0] k_wide;

  // ---------------------------------------------------------------------------
  // Command decode. A led_count above NUM_LEDS is clipped. An all-LED command
  // walks from LED 0 up to the count; a single-LED command beyond the count
  // does nothing, and so does the unused opcode.
  // ---------------------------------------------------------------------------
  always_comb begin
    in_sel    = s_axis_tdata[4:0];
    in_col[0] = s_axis_tdata[12:5];
    in_col[1] = s_axis_tdata[20:13];
    in_col[2] = s_axis_tdata[28:21];
    in_steps  = s_axis_tdata[44:29];

    n_b   = ({3'b0, led_count} > NUM_LEDS_B) ? NUM_LEDS_B : {3'b0, led_count};
    n     = n_b[CNT_W-1:0];
    sel_b = {3'b0, in_sel};

    sel_lo = '0;
    sel_hi = n;
    sel_go = (n != '0);
    case (s_axis_tuser) inside
      OP_TICK: begin
      end
      OP_SET_NOW, OP_FADE_TO: begin
        if (sel_b != 8'd0) begin
          if (sel_b <= n_b) begin
            sel_lo = CNT_W'(sel_b - 8'd1);
            sel_hi = CNT_W'(sel_b);
          end else begin
            sel_go = 1'b0;
          end
        end
      end
      default: sel_go = 1'b0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Table RAM. Each LED is read, changed in the working register and written
  // back before the next LED is read, so accesses never overlap. An entry that
  // was never written since reset reads as all zero.
  // ---------------------------------------------------------------------------
  assign addr   = k[IDX_W-1:0];
  assign ram_re = (state == S_READ);
  assign wb_go  = (op != OP_TICK) || !out_valid || m_axis_tready;
  assign ram_we = (state == S_WB) && wb_go;
  assign k_inc  = k + 1'b1;
  assign out_load = (state == S_WB) && wb_go && (op == OP_TICK);

  rlf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_LEDS)
  ) u_rlf_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (work),
    .re    (ram_re),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  assign rd_entry = valid[addr] ? led_entry_t'(ram_rdata) : '0;

  // ---------------------------------------------------------------------------
  // Entry as loaded into the working register. set_now replaces both colors
  // and stops the fade. A tick leaves an idle LED as it is, counts a fading
  // LED down, and on the final step snaps the color to the target.
  // ---------------------------------------------------------------------------
  always_comb begin
    work_next  = rd_entry;
    load_state = S_WB;
    case (op) inside
      OP_SET_NOW: begin
        work_next.cur        = col;
        work_next.tgt        = col;
        work_next.steps_left = '0;
      end
      OP_FADE_TO: begin
        load_state = S_FD_START;
      end
      default: begin
        if (rd_entry.steps_left != '0) begin
          work_next.steps_left = rd_entry.steps_left - 1'b1;
          if (rd_entry.steps_left == STL_W'(1)) begin
            work_next.cur = rd_entry.tgt;
          end else begin
            load_state = S_TA;
          end
        end
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Fade set-up: per channel the slope is 100 * (target - current) / steps,
  // truncated toward zero. The divider works on magnitudes and the sign is
  // put back afterwards.
  // ---------------------------------------------------------------------------
  always_comb begin
    abs_diff = (col[ch] >= work.cur[ch]) ? (col[ch] - work.cur[ch])
                                         : (work.cur[ch] - col[ch]);
    div_req.start = (state == S_FD_START);
    div_req.num   = DIV_NUM_W'(abs_diff * 7'(SCALE));
    div_req.den   = steps_eff;
    quo_ext       = {1'b0, div_rsp.quo};
  end

  rlf_div u_rlf_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // ---------------------------------------------------------------------------
  // Tick datapath, three registered steps per channel:
  //   TA: t = 100*cur + m and the product m*s (s = remaining steps)
  //   TB: lag test e = 100*dest - m*s - t; a lagging channel gets m twice;
  //       then +50 for rounding
  //   TC: divide by 100 through a reciprocal multiply and clamp to 0..255
  // ---------------------------------------------------------------------------
  always_comb begin
    m_sg    = $signed(work.slope[ch]);
    s_sg    = $signed({1'b0, work.steps_left[STEPS_W-1:0]});
    cur100  = 15'(work.cur[ch] * 7'(SCALE));
    dest100 = 15'(work.tgt[ch] * 7'(SCALE));
    err     = $signed({20'b0, dest100}) - 35'(prod) - 35'(t_a);
    lag     = ((m_sg > 0) && (err > 35'(m_sg))) || ((m_sg < 0) && (err < 35'(m_sg)));
    recip_prod = 28'(t_b[14:0] * 13'(RECIP));
    if (t_b < 0) begin
      chan_val = '0;
    end else if (t_b >= 19'(SAT_LIMIT)) begin
      chan_val = '1;
    end else begin
      chan_val = recip_prod[RECIP_SH+COLOR_W-1:RECIP_SH];
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer, table working register and output register. A report word is
  // loaded in the same cycle as the previous one leaves, so the output never
  // sits idle while the walk has a word ready.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      led_count <= LED_COUNT_RST;
      valid     <= '0;
    end else begin
      if (cfg_valid) begin
        led_count <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op        <= s_axis_tuser;
            col       <= in_col;
            steps_eff <= (in_steps == '0) ? STEPS_W'(1) : in_steps;
            k         <= sel_lo;
            hi        <= sel_hi;
            state     <= sel_go ? S_READ : S_IDLE;
          end
        end

        S_READ: begin
          state <= S_LOAD;
        end

        S_LOAD: begin
          work  <= work_next;
          ch    <= 2'd0;
          state <= load_state;
        end

        S_FD_START: begin
          neg   <= (col[ch] < work.cur[ch]);
          state <= S_FD_WAIT;
        end

        S_FD_WAIT: begin
          if (div_rsp.done) begin
            work.slope[ch] <= neg ? (SLOPE_W'(0) - quo_ext) : quo_ext;
            work.tgt[ch]   <= col[ch];
            if (ch == 2'd2) begin
              work.steps_left <= {1'b0, steps_eff} + 1'b1;
              state           <= S_WB;
            end else begin
              ch    <= ch + 1'b1;
              state <= S_FD_START;
            end
          end
        end

        S_TA: begin
          prod  <= m_sg * s_sg;
          t_a   <= $signed({4'b0, cur100}) + 19'(m_sg);
          state <= S_TB;
        end

        S_TB: begin
          t_b   <= t_a + (lag ? 19'(m_sg) : 19'sd0) + 19'(HALF);
          state <= S_TC;
        end

        S_TC: begin
          work.cur[ch] <= chan_val;
          if (ch == 2'd2) begin
            state <= S_WB;
          end else begin
            ch    <= ch + 1'b1;
            state <= S_TA;
          end
        end

        S_WB: begin
          // A tick's report waits here until the output register is free.
          if (wb_go) begin
            valid[addr] <= 1'b1;
            if (op == OP_TICK) begin
              out_idx   <= k_wide[LED_IDX_W-1:0];
              out_col   <= work.cur;
              out_last  <= (k_inc == hi);
            end
            k     <= k_inc;
            state <= (k_inc == hi) ? S_IDLE : S_READ;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign k_wide = {{LED_IDX_W{1'b0}}, k};

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0, out_col[2], out_col[1], out_col[0], out_idx};
  assign m_axis_tlast  = out_last;

endmodule

@@ hdl/rlf_checker.sv @@
// Port-level checker for the RGB linear fader, bound to the top level.
// Depends on rlf_pkg and on the macros in assert_macros.svh.
`include "assert_macros.svh"

module rlf_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [rlf_pkg::OPCODE_W-1:0]    s_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [rlf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tlast
);
  import rlf_pkg::*;

  // After reset the block is ready for a command and has no word pending.
  property p_reset_idle;
    rst |=> (!m_axis_tvalid && s_axis_tready);
  endproperty

  // A stalled report word holds.
  property p_out_hold;
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast));
  endproperty

  // While a tick is partway through its LEDs no new command is taken.
  property p_busy_mid_tick;
    (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready;
  endproperty

  // Only a tick produces report words.
  property p_no_word_from_set;
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser != OP_TICK) && !m_axis_tvalid)
      |=> !m_axis_tvalid;
  endproperty

  `ASSERT_CLK_NR(a_reset_idle, clk, p_reset_idle, "not idle after reset")
  `ASSERT_CLK(a_out_hold, clk, rst, p_out_hold, "stalled word changed")
  `ASSERT_CLK(a_busy_mid_tick, clk, rst, p_busy_mid_tick, "command taken during a tick")
  `ASSERT_CLK(a_no_word_from_set, clk, rst, p_no_word_from_set, "word from a non-tick command")

endmodule

bind rgb_linear_fader rlf_checker u_rlf_checker (.*);

@@ bench/tb_rgb_linear_fader.sv @@
// Self-checking testbench for the RGB linear fader (rgb_linear_fader).
// Needs the fader RTL and rlf_pkg; drives command words and checks every color report
// word against a cycle-free model of the LED fade table kept inside this bench.
module tb_rgb_linear_fader;
  timeunit 1ns;
  timeprecision 1ps;

  import rlf_pkg::*;

  localparam int NLEDS = NUM_LEDS_DEF;

  // Opcode 3 has no meaning; the block must swallow it without a report.
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  // Receiver hold-off that forces the fader to back up into its input.
  localparam int HOLD_CYCLES = 400;
  // A fade_to over all 16 LEDs runs the slope divider on every channel of every LED after
  // its word was taken, so this much quiet time is left before a register write and before
  // the final verdict.
  localparam int SETTLE_CYCLES = 1000;
  // Upper bound on waiting for outstanding reports to drain.
  localparam int DRAIN_LIMIT = 20000;
  localparam int RAND_ITEMS = 390;
  localparam int RAND_PHASES = 6;
  localparam int MAX_SHOWN = 10;
  localparam int TIMEOUT_NS = 80_000_000;
  localparam int DIR_ROWS = 30;

  // One color report word as seen on the output stream.
  typedef struct packed {
    logic [LED_IDX_W-1:0] idx;
    logic [COLOR_W-1:0]   red;
    logic [COLOR_W-1:0]   green;
    logic [COLOR_W-1:0]   blue;
    logic                 last;
  } color_report_t;

  typedef enum logic {ROW_CMD, ROW_CFG} row_kind_t;

  // A directed stimulus row. On a ROW_CFG row the sel field carries the new
  // led_count. On a tick row with pinned set, every LED in use is expected to
  // report the color given in the row instead of the modeled one.
  typedef struct packed {
    row_kind_t            kind;
    logic [OPCODE_W-1:0]  op;
    logic [SEL_W-1:0]     sel;
    logic [COLOR_W-1:0]   red;
    logic [COLOR_W-1:0]   green;
    logic [COLOR_W-1:0]   blue;
    logic [STEPS_W-1:0]   steps;
    logic                 pinned;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [COUNT_W-1:0]     cfg_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // led_select[4:0], red[12:5], green[20:13], blue[28:21], steps[44:29], zero[47:45]
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  // opcode[1:0]
  logic [OPCODE_W-1:0]    s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // led_index[3:0], out_red[11:4], out_green[19:12], out_blue[27:20], zero[31:28]
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  rgb_linear_fader #(
    .NUM_LEDS(NLEDS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // 20 ns clock period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 0;
  end

  // ---------------------------------------------------------------------------
  // Model of the fade table. It is updated at the edge where a command word is
  // taken, and every tick pushes the reports it must cause onto report_q.
  // ---------------------------------------------------------------------------
  logic [COLOR_W-1:0] cur_col [NLEDS][3];
  logic [COLOR_W-1:0] tgt_col [NLEDS][3];
  int                 slope_q [NLEDS][3];   // slope in hundredths of a level per tick
  int unsigned        steps_rem [NLEDS];    // zero means the LED is not fading
  int unsigned        led_count_m;
  color_report_t      report_q [$];
  int                 words_applied = 0;    // command words that were not dropped
  int                 fail_cnt = 0;
  int                 hold_req = 0;         // bumped to ask the receiver for a long hold
  bit                 tvalid_up = 1'b0;     // mirrors what s_axis_tvalid was last driven to

  // One channel of one tick along the ideal line. When the rounded position
  // lags the line by more than one slope, the slope is applied twice to catch up.
  function automatic logic [COLOR_W-1:0] ramp_channel(logic [COLOR_W-1:0] now_lvl,
                                                      logic [COLOR_W-1:0] goal,
                                                      int slope, int unsigned left);
    longint m, t, e, v;
    m = slope;
    t = 100 * longint'(now_lvl) + m;
    e = 100 * longint'(goal) - m * longint'(left) - t;
    if ((m > 0 && e > m) || (m < 0 && e < m)) t += m;
    t += 50;
    if (t < 0) v = 0;
    else begin
      v = t / 100;
      if (v > 255) v = 255;
    end
    return v[COLOR_W-1:0];
  endfunction

  function automatic void tick_led(int k);
    int c;
    if (steps_rem[k] == 0) return;
    steps_rem[k]--;
    // On the final step the LED lands exactly on its target.
    if (steps_rem[k] == 0) begin
      for (c = 0; c < 3; c++) cur_col[k][c] = tgt_col[k][c];
      return;
    end
    for (c = 0; c < 3; c++)
      cur_col[k][c] = ramp_channel(cur_col[k][c], tgt_col[k][c], slope_q[k][c], steps_rem[k]);
  endfunction

  function automatic void fade_table_update(logic [OPCODE_W-1:0] op, logic [SEL_W-1:0] sel,
                                            logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g,
                                            logic [COLOR_W-1:0] b, logic [STEPS_W-1:0] st,
                                            logic pinned);
    int unsigned   n, lo, hi;
    int            k, c, diff, span;
    logic [COLOR_W-1:0] col [3];
    color_report_t rep;
    // A led_count beyond the table size walks the whole table.
    n = (led_count_m > NLEDS) ? NLEDS : led_count_m;
    col[0] = r;
    col[1] = g;
    col[2] = b;
    if (op == OP_SET_NOW || op == OP_FADE_TO) begin
      if (sel == 0) begin
        lo = 0;
        hi = n;
      end else if (sel <= n) begin
        lo = sel - 1;
        hi = sel;
      end else begin
        return;   // LED beyond the count: the word is dropped.
      end
      words_applied++;
      for (k = lo; k < hi; k++) begin
        if (op == OP_SET_NOW) begin
          for (c = 0; c < 3; c++) begin
            cur_col[k][c] = col[c];
            tgt_col[k][c] = col[c];
          end
          steps_rem[k] = 0;
        end else begin
          // Zero steps behaves as a one-step fade.
          span = (st == 0) ? 1 : int'(st);
          steps_rem[k] = span + 1;
          for (c = 0; c < 3; c++) begin
            diff = int'(col[c]) - int'(cur_col[k][c]);
            tgt_col[k][c] = col[c];
            slope_q[k][c] = (diff * 100) / span;   // truncates toward zero
          end
        end
      end
    end else if (op == OP_TICK) begin
      words_applied++;
      for (k = 0; k < n; k++) begin
        tick_led(k);
        rep.idx   = 4'(k);
        rep.red   = pinned ? r : cur_col[k][0];
        rep.green = pinned ? g : cur_col[k][1];
        rep.blue  = pinned ? b : cur_col[k][2];
        rep.last  = (k + 1 == n);
        report_q.push_back(rep);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Report checker. Sampling happens at the rising edge, so it sees the values
  // that were present when the handshake took place.
  // ---------------------------------------------------------------------------
  task automatic log_failure(input string msg);
    fail_cnt++;
    if (fail_cnt <= MAX_SHOWN) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    color_report_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.idx   = m_axis_tdata[3:0];
      got.red   = m_axis_tdata[11:4];
      got.green = m_axis_tdata[19:12];
      got.blue  = m_axis_tdata[27:20];
      got.last  = m_axis_tlast;
      if (report_q.size() == 0) begin
        log_failure($sformatf("unexpected report: led %0d rgb %02h %02h %02h last %0b",
                              got.idx, got.red, got.green, got.blue, got.last));
      end else begin
        want = report_q.pop_front();
        if (got.idx !== want.idx || got.red !== want.red || got.green !== want.green ||
            got.blue !== want.blue || got.last !== want.last) begin
          log_failure($sformatf(
            "report mismatch: expected led %0d rgb %02h %02h %02h last %0b, got led %0d rgb %02h %02h %02h last %0b",
            want.idx, want.red, want.green, want.blue, want.last,
            got.idx, got.red, got.green, got.blue, got.last));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver. Ready is high for random stretches broken by gaps, mostly short
  // and now and then long. On request it holds off for HOLD_CYCLES so that
  // the fader fills up and must stall its input.
  // ---------------------------------------------------------------------------
  initial begin : report_sink
    int r, low_len, hold_seen;
    hold_seen = 0;
    @(posedge clk);
    forever begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
        r = $urandom_range(0, 99);
        if (r < 50) low_len = 0;
        else if (r < 90) low_len = $urandom_range(1, 3);
        else low_len = $urandom_range(20, 80);
        if (low_len > 0) begin
          m_axis_tready <= 1'b0;
          repeat (low_len) @(posedge clk);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side. All drives happen right after a rising edge.
  // ---------------------------------------------------------------------------
  task automatic drop_valid();
    if (tvalid_up) begin
      s_axis_tvalid <= 1'b0;
      tvalid_up = 1'b0;
    end
  endtask

  // Offers one command word and returns at the edge where it is taken; valid
  // stays high so that a following word can go out without a bubble.
  task automatic send_word(input logic [OPCODE_W-1:0] op, input logic [SEL_W-1:0] sel,
                           input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
                           input logic [COLOR_W-1:0] b, input logic [STEPS_W-1:0] st,
                           input logic pinned);
    s_axis_tuser  <= op;
    s_axis_tdata  <= {3'b000, st, b, g, r, sel};
    s_axis_tvalid <= 1'b1;
    tvalid_up = 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    fade_table_update(op, sel, r, g, b, st, pinned);
  endtask

  // Ticks ignore the other fields, so those carry random bits.
  task automatic send_tick();
    send_word(OP_TICK, 5'($urandom_range(0, 31)), 8'($urandom), 8'($urandom), 8'($urandom),
              16'($urandom), 1'b0);
  endtask

  task automatic gap_sender();
    int r, n;
    r = $urandom_range(0, 99);
    if (r < 65) n = 0;
    else if (r < 93) n = $urandom_range(1, 3);
    else n = $urandom_range(15, 60);
    if (n > 0) begin
      drop_valid();
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    int spin;
    spin = 0;
    while (report_q.size() != 0 && spin < DRAIN_LIMIT) begin
      @(posedge clk);
      spin++;
    end
  endtask

  // The register is only written with the fader idle: no report outstanding and
  // enough quiet cycles for a long fade_to walk to finish.
  task automatic write_led_count(input logic [COUNT_W-1:0] cnt);
    drop_valid();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_data  <= cnt;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    led_count_m = cnt;
  endtask

  // Colors lean on the extremes now and then.
  function automatic logic [COLOR_W-1:0] pick_level();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hff;
    return 8'($urandom_range(0, 255));
  endfunction

  // Mostly short fades so that they run to their end; a few very long ones.
  function automatic logic [STEPS_W-1:0] pick_steps();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'($urandom_range(0, 12));
    if (r < 88) return 16'($urandom_range(13, 40));
    if (r < 97) return 16'($urandom_range(41, 1000));
    return 16'($urandom_range(60000, 65535));
  endfunction

  function automatic logic [SEL_W-1:0] pick_select();
    if ($urandom_range(0, 4) == 0) return 5'd0;
    return 5'($urandom_range(1, 16));
  endfunction

  // One random sequence. Most are a fade followed by enough ticks to see it
  // land; some are cut short, and the rest are set_now, lone ticks and noise.
  task automatic run_sequence();
    int kind, ticks, i;
    logic [STEPS_W-1:0] st;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      st = pick_steps();
      send_word(OP_FADE_TO, pick_select(), pick_level(), pick_level(), pick_level(), st, 1'b0);
      gap_sender();
      ticks = (st < 14) ? int'(st) + 2 : $urandom_range(2, 10);
      if ($urandom_range(0, 99) < 15) ticks = $urandom_range(0, ticks);
      for (i = 0; i < ticks; i++) begin
        send_tick();
        gap_sender();
      end
    end else if (kind < 75) begin
      send_word(OP_SET_NOW, pick_select(), pick_level(), pick_level(), pick_level(),
                16'($urandom), 1'b0);
      gap_sender();
      ticks = $urandom_range(1, 2);
      for (i = 0; i < ticks; i++) begin
        send_tick();
        gap_sender();
      end
    end else if (kind < 88) begin
      send_tick();
      gap_sender();
    end else begin
      // Noise: any opcode, the unused one included, with arbitrary fields.
      send_word(2'($urandom_range(0, 3)), 5'($urandom_range(0, 16)), 8'($urandom),
                8'($urandom), 8'($urandom), 16'($urandom), 1'b0);
      gap_sender();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed table, then random phases at several counts.
  // ---------------------------------------------------------------------------
  dir_row_t dir_tab [DIR_ROWS];

  initial begin : stimulus
    int i, k, c, ph, budget;
    logic [COUNT_W-1:0] cnt;

    for (k = 0; k < NLEDS; k++) begin
      for (c = 0; c < 3; c++) begin
        cur_col[k][c] = '0;
        tgt_col[k][c] = '0;
        slope_q[k][c] = 0;
      end
      steps_rem[k] = 0;
    end
    led_count_m = LED_COUNT_RST;

    // After reset every LED is off.
    dir_tab[0]  = '{ROW_CMD, OP_TICK,    5'd0,  8'h00, 8'h00, 8'h00, 16'd0,     1'b1};
    dir_tab[1]  = '{ROW_CMD, OP_SET_NOW, 5'd0,  8'hff, 8'hff, 8'hff, 16'd0,     1'b0};
    dir_tab[2]  = '{ROW_CMD, OP_TICK,    5'd0,  8'hff, 8'hff, 8'hff, 16'd0,     1'b1};
    dir_tab[3]  = '{ROW_CMD, OP_SET_NOW, 5'd1,  8'h00, 8'h00, 8'h00, 16'd0,     1'b0};
    dir_tab[4]  = '{ROW_CMD, OP_SET_NOW, 5'd16, 8'h12, 8'h34, 8'h56, 16'd0,     1'b0};
    dir_tab[5]  = '{ROW_CMD, OP_TICK,    5'd0,  8'h00, 8'h00, 8'h00, 16'd0,     1'b0};
    // A fade of zero steps acts as a one-step fade.
    dir_tab[6]  = '{ROW_CMD, OP_FADE_TO, 5'd2,  8'h00, 8'h80, 8'hff, 16'd0,     1'b0};
    dir_tab[7]  = '{ROW_CMD, OP_TICK,    5'd0,  8'h00, 8'h00, 8'h00, 16'd0,     1'b0};
    dir_tab[8]  = '{ROW_CMD, OP_TICK,    5'd0,  8'h00, 8'h00, 8'h00, 16'd0,     1'b0};
    // Fade all LEDs down to black; the fifth tick lands every one of them.
    dir_tab[9]  = '{ROW_CMD, OP_FADE_TO, 5'd0,  8'h00, 8'h00, 8'h00, 16'd4,     1'b0};
    dir_tab[10] = '{ROW_CMD, OP_TICK,    5'd0,  8'h00, 8'h00, 8'h00, 16'd0,     1'b0};
    dir_tab[11] = '{ROW_CMD, OP_TICK,    5'd0,  8'h00, 8'h00, 8'h00, 16'd0,     1'b0};
    dir_tab[12] = '{ROW_CMD, OP_TICK,    5'd0,  8'h00, 8'h00, 8'h00, 16'd0,     1'b0};
    dir_tab[13] = '{ROW_CMD, OP_TICK,    5'd0,  8'h00, 8'h00, 8'h00, 16'd0,     1'b0};
    dir_tab[14] = '{ROW_CMD, OP_TICK,    5'd0,  8'h00, 8'h00, 8'h00, 16'd0,     1'b1};
    dir_tab[15] = '{ROW_CMD, OP_FADE_TO, 5'd3,  8'hff, 8'hff, 8'hff, 16'hffff,  1'b0};
    dir_tab[16] = '{ROW_CMD, OP_TICK,    5'd0,  8'h00, 8'h00, 8'h00, 16'd0,     1'b0};
    // The unused opcode must not disturb the table.
    dir_tab[17] = '{ROW_CMD, OP_UNUSED,  5'd0,  8'haa, 8'h55, 8'haa, 16'hffff,  1'b0};
    dir_tab[18] = '{ROW_CMD, OP_TICK,    5'd0,  8'h00, 8'h00, 8'h00, 16'd0,     1'b0};
    // With three LEDs in use, selects beyond three are dropped.
    dir_tab[19] = '{ROW_CFG, OP_TICK,    5'd3,  8'h00, 8'h00, 8'h00, 16'd0,     1'b0};
    dir_tab[20] = '{ROW_CMD, OP_SET_NOW, 5'd16, 8'hff, 8'h00, 8'hff, 16'd0,     1'b0};
    dir_tab[21] = '{ROW_CMD, OP_FADE_TO, 5'd4,  8'hff, 8'hff, 8'hff, 16'd2,     1'b0};
    dir_tab[22] = '{ROW_CMD, OP_FADE_TO, 5'd3,  8'h01, 8'hfe, 8'h80, 16'd1,     1'b0};
    dir_tab[23] = '{ROW_CMD, OP_TICK,    5'd0,  8'h00, 8'h00, 8'h00, 16'd0,     1'b0};
    // No LED in use: a tick reports nothing and all-LED commands do nothing.
    dir_tab[24] = '{ROW_CFG, OP_TICK,    5'd0,  8'h00, 8'h00, 8'h00, 16'd0,     1'b0};
    dir_tab[25] = '{ROW_CMD, OP_TICK,    5'd0,  8'h00, 8'h00, 8'h00, 16'd0,     1'b0};
    dir_tab[26] = '{ROW_CMD, OP_SET_NOW, 5'd0,  8'hff, 8'hff, 8'hff, 16'd0,     1'b0};
    // A count above the table size walks the whole table.
    dir_tab[27] = '{ROW_CFG, OP_TICK,    5'd31, 8'h00, 8'h00, 8'h00, 16'd0,     1'b0};
    dir_tab[28] = '{ROW_CMD, OP_SET_NOW, 5'd0,  8'h20, 8'h40, 8'h60, 16'd0,     1'b0};
    dir_tab[29] = '{ROW_CMD, OP_TICK,    5'd0,  8'h20, 8'h40, 8'h60, 16'd0,     1'b1};

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < DIR_ROWS; i++) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        write_led_count(dir_tab[i].sel);
      end else begin
        send_word(dir_tab[i].op, dir_tab[i].sel, dir_tab[i].red, dir_tab[i].green,
                  dir_tab[i].blue, dir_tab[i].steps, dir_tab[i].pinned);
        gap_sender();
      end
    end

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: cnt = 5'd1;
        1: cnt = 5'd16;
        2: cnt = 5'($urandom_range(2, 15));
        3: cnt = 5'd16;
        default: cnt = 5'($urandom_range(1, 16));
      endcase
      write_led_count(cnt);
      if (ph == 1) begin
        // Ask the receiver to hold off while ticks keep arriving back to back.
        hold_req <= hold_req + 1;
        for (i = 0; i < 10; i++) send_tick();
      end
      budget = words_applied + RAND_ITEMS / RAND_PHASES;
      while (words_applied < budget) run_sequence();
    end

    drop_valid();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (report_q.size() != 0)
      log_failure($sformatf("%0d expected reports never arrived", report_q.size()));
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("status: fail");
    $finish;
  end

endmodule
